[hdl/owbm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_pkg: shared types and constants of the 1-Wire bus master
// Action codes, configuration register indexes and reset values, the
// configuration bundle and the result beat layout.
// ----------------------------------------------------------------------------
package owbm_pkg;

  // Item action codes; six and seven carry no meaning.
  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_RESET      = 3'd1,
    ACT_WRITE_BYTE = 3'd2,
    ACT_READ_BYTE  = 3'd3,
    ACT_WRITE_BIT  = 3'd4,
    ACT_READ_BIT   = 3'd5
  } action_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_RESET_LOW    = 3'd0;
  localparam logic [2:0] REG_PRESENCE_DLY = 3'd1;
  localparam logic [2:0] REG_RESET_REC    = 3'd2;
  localparam logic [2:0] REG_ZERO_LOW     = 3'd3;
  localparam logic [2:0] REG_SHORT_LOW    = 3'd4;
  localparam logic [2:0] REG_READ_SAMPLE  = 3'd5;
  localparam logic [2:0] REG_SLOT_LENGTH  = 3'd6;

  // Reset values of the timing registers, in microseconds.
  localparam logic [9:0] RST_RESET_LOW    = 10'd480;
  localparam logic [9:0] RST_PRESENCE_DLY = 10'd70;
  localparam logic [9:0] RST_RESET_REC    = 10'd410;
  localparam logic [9:0] RST_ZERO_LOW     = 10'd60;
  localparam logic [9:0] RST_SHORT_LOW    = 10'd6;
  localparam logic [9:0] RST_READ_SAMPLE  = 10'd15;
  localparam logic [9:0] RST_SLOT_LENGTH  = 10'd70;

  // Timing register bundle as stored.
  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [9:0] presence_sample_delay;
    logic [9:0] reset_recovery_time;
    logic [9:0] zero_low_time;
    logic [9:0] short_low_time;
    logic [9:0] read_sample_time;
    logic [9:0] slot_length;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;
  } res_t;

endpackage

[hdl/owbm_cmd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_cmd_if: command and tick channel
// Valid/ready channel carrying one action item per beat.
// ----------------------------------------------------------------------------
interface owbm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] data;
  logic       bus_sample;

  modport source (output valid, output action, output data, output bus_sample,
                  input ready);
  modport sink (input valid, input action, input data, input bus_sample,
                output ready);
endinterface

[hdl/owbm_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_res_if: result channel
// Valid/ready channel carrying one status beat per accepted item.
// ----------------------------------------------------------------------------
interface owbm_res_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] read_data;
  logic       rejected;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output presence, output read_data, output rejected, input ready);
  modport sink (input valid, input drive_low, input busy_res, input done_res,
                input presence, input read_data, input rejected, output ready);
endinterface

[hdl/owbm_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
interface owbm_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [9:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/owbm_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_cfg_regs: timing register file
// Holds the seven timing registers; a write beat to an index beyond the
// list is ignored.
// ----------------------------------------------------------------------------
module owbm_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  logic [2:0]     wr_index,
  input  logic [9:0]     wr_data,
  output owbm_pkg::cfg_t cfg
);

  owbm_pkg::cfg_t regs;

  // Register writes, reset to the standard timings.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.reset_low_time        <= owbm_pkg::RST_RESET_LOW;
      regs.presence_sample_delay <= owbm_pkg::RST_PRESENCE_DLY;
      regs.reset_recovery_time   <= owbm_pkg::RST_RESET_REC;
      regs.zero_low_time         <= owbm_pkg::RST_ZERO_LOW;
      regs.short_low_time        <= owbm_pkg::RST_SHORT_LOW;
      regs.read_sample_time      <= owbm_pkg::RST_READ_SAMPLE;
      regs.slot_length           <= owbm_pkg::RST_SLOT_LENGTH;
    end else if (wr_en) begin
      case (wr_index)
        owbm_pkg::REG_RESET_LOW:    regs.reset_low_time        <= wr_data;
        owbm_pkg::REG_PRESENCE_DLY: regs.presence_sample_delay <= wr_data;
        owbm_pkg::REG_RESET_REC:    regs.reset_recovery_time   <= wr_data;
        owbm_pkg::REG_ZERO_LOW:     regs.zero_low_time         <= wr_data;
        owbm_pkg::REG_SHORT_LOW:    regs.short_low_time        <= wr_data;
        owbm_pkg::REG_READ_SAMPLE:  regs.read_sample_time      <= wr_data;
        owbm_pkg::REG_SLOT_LENGTH:  regs.slot_length           <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

[hdl/owbm_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_engine: bus sequencing state and single-item step logic
// Holds the operation state, the microsecond counter, the bit counter and
// the shift byte, and works out the result of one item combinationally.
// ----------------------------------------------------------------------------
module owbm_engine #(
  parameter int TIME_BITS = 11
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [2:0]     action,
  input  logic [7:0]     data,
  input  logic           bus_sample,
  input  owbm_pkg::cfg_t cfg,
  output owbm_pkg::res_t res
);

  localparam int CW = (TIME_BITS > 10) ? TIME_BITS : 10;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  typedef enum logic [6:0] {
    OP_IDLE      = 7'b0000001,
    OP_RST_LOW   = 7'b0000010,
    OP_RST_WAIT  = 7'b0000100,
    OP_RST_REC   = 7'b0001000,
    OP_WRITE     = 7'b0010000,
    OP_READ_BYTE = 7'b0100000,
    OP_READ_BIT  = 7'b1000000
  } op_t;

  // A time of zero counts as one; a time beyond the counter saturates.
  function automatic logic [TIME_BITS-1:0] lim(input logic [9:0] x);
    logic [CW-1:0] xe;
    logic [CW-1:0] me;
    xe = CW'(x);
    me = CW'(TMAX);
    if (x == 10'd0) return TIME_BITS'(1);
    else if (xe > me) return TMAX;
    else return xe[TIME_BITS-1:0];
  endfunction

  op_t                  op, op_next;
  logic [TIME_BITS-1:0] tcount, tcount_next;
  logic [3:0]           bits_left, bits_left_next;
  logic [7:0]           shift, shift_next;
  logic                 pres, pres_next;

  logic [TIME_BITS-1:0] tc_inc;
  logic [TIME_BITS-1:0] l_rst_low, l_pres, l_rec, l_zero, l_short, l_samp, l_slot;
  logic [TIME_BITS-1:0] low;
  logic [3:0]           bl_dec;
  logic                 slot_end;
  logic                 is_cmd;

  assign l_rst_low = lim(cfg.reset_low_time);
  assign l_pres    = lim(cfg.presence_sample_delay);
  assign l_rec     = lim(cfg.reset_recovery_time);
  assign l_zero    = lim(cfg.zero_low_time);
  assign l_short   = lim(cfg.short_low_time);
  assign l_samp    = lim(cfg.read_sample_time);
  assign l_slot    = lim(cfg.slot_length);

  // Saturating microsecond count and decremented bit count.
  assign tc_inc = (tcount == TMAX) ? tcount : tcount + TIME_BITS'(1);
  assign bl_dec = (bits_left != 4'd0) ? bits_left - 4'd1 : 4'd0;
  assign low    = shift[0] ? l_short : l_zero;

  assign is_cmd = (action == owbm_pkg::ACT_RESET) || (action == owbm_pkg::ACT_WRITE_BYTE) ||
                  (action == owbm_pkg::ACT_READ_BYTE) || (action == owbm_pkg::ACT_WRITE_BIT) ||
                  (action == owbm_pkg::ACT_READ_BIT);

  // Next state and result of the item.
  always_comb begin
    op_next        = op;
    tcount_next    = tcount;
    bits_left_next = bits_left;
    shift_next     = shift;
    pres_next      = pres;
    slot_end       = 1'b0;
    res            = '0;

    if (is_cmd) begin
      if (op != OP_IDLE) begin
        res.rejected = 1'b1;
      end else begin
        tcount_next = '0;
        case (action)
          owbm_pkg::ACT_RESET: begin
            op_next   = OP_RST_LOW;
            pres_next = 1'b0;
          end
          owbm_pkg::ACT_WRITE_BYTE: begin
            op_next        = OP_WRITE;
            shift_next     = data;
            bits_left_next = 4'd8;
          end
          owbm_pkg::ACT_WRITE_BIT: begin
            op_next        = OP_WRITE;
            shift_next     = {7'd0, data[0]};
            bits_left_next = 4'd1;
          end
          owbm_pkg::ACT_READ_BYTE: begin
            op_next        = OP_READ_BYTE;
            shift_next     = 8'd0;
            bits_left_next = 4'd8;
          end
          default: begin
            op_next        = OP_READ_BIT;
            shift_next     = 8'd0;
            bits_left_next = 4'd1;
          end
        endcase
      end
    end else if (action == owbm_pkg::ACT_TICK) begin
      case (op)
        OP_RST_LOW: begin
          res.drive_low = 1'b1;
          tcount_next   = tc_inc;
          if (tc_inc >= l_rst_low) begin
            op_next     = OP_RST_WAIT;
            tcount_next = '0;
          end
        end
        OP_RST_WAIT: begin
          tcount_next = tc_inc;
          if (tc_inc >= l_pres) begin
            pres_next   = ~bus_sample;
            op_next     = OP_RST_REC;
            tcount_next = '0;
          end
        end
        OP_RST_REC: begin
          tcount_next = tc_inc;
          if (tc_inc >= l_rec) begin
            op_next      = OP_IDLE;
            tcount_next  = '0;
            res.done_res = 1'b1;
          end
        end
        OP_WRITE: begin
          res.drive_low = (tcount < low);
          tcount_next   = tc_inc;
          if (tc_inc >= l_slot) begin
            shift_next = {1'b0, shift[7:1]};
            slot_end   = 1'b1;
          end
        end
        OP_READ_BYTE, OP_READ_BIT: begin
          // The slot opens by shifting the byte; the sample lands in bit 7.
          if (tcount == '0) shift_next = {1'b0, shift[7:1]};
          res.drive_low = (tcount < l_short);
          tcount_next   = tc_inc;
          if ((tc_inc == l_samp) && bus_sample) shift_next[7] = 1'b1;
          if (tc_inc >= l_slot) slot_end = 1'b1;
        end
        default: begin
          op_next = OP_IDLE;
        end
      endcase

      // Close of a write or read slot.
      if (slot_end) begin
        tcount_next    = '0;
        bits_left_next = bl_dec;
        if (bl_dec == 4'd0) begin
          if (op == OP_READ_BYTE) res.read_data = shift_next;
          else if (op == OP_READ_BIT) res.read_data = {7'd0, shift_next[7]};
          op_next      = OP_IDLE;
          res.done_res = 1'b1;
        end
      end
    end

    res.busy_res = (op_next != OP_IDLE);
    res.presence = pres_next;
  end

  // State registers advance once per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      op        <= OP_IDLE;
      tcount    <= '0;
      bits_left <= 4'd0;
      shift     <= 8'd0;
      pres      <= 1'b0;
    end else if (step) begin
      op        <= op_next;
      tcount    <= tcount_next;
      bits_left <= bits_left_next;
      shift     <= shift_next;
      pres      <= pres_next;
    end
  end

endmodule

[hdl/one_wire_bus_master_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master_core: 1-Wire bus master stepped by microsecond ticks
//
// The cmd channel takes one item per beat: a tick (one microsecond, with
// the sampled bus level) or a command (reset, write or read of a bit or a
// byte). Every accepted item gives exactly one beat on the res channel,
// carrying the line drive for that microsecond and the status flags.
// Commands arriving while a sequence runs are flagged as rejected.
// The cfg channel writes the seven timing registers; it is always ready
// and should only be used while no items are in flight.
//
// A cmd beat reaches its res beat through the input register, then the
// step logic and the result register. One item is accepted per cycle while
// results are taken; the step logic with the single state update per item
// sets that figure. When the receiver stalls, a waiting result is held and
// one further item may still be taken into the input register; after that
// cmd.ready falls until the result is taken. Reset empties both registers,
// returns the engine to idle and loads the standard timings.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core #(
  parameter int TIME_BITS = 11
) (
  input  logic         clk,
  input  logic         rst,
  owbm_cmd_if.sink     cmd,
  owbm_res_if.source   res,
  owbm_cfg_if.sink     cfg
);

  owbm_pkg::cfg_t cfg_regs;
  owbm_pkg::res_t step_res;
  owbm_pkg::res_t out_res;

  logic       in_vld;
  logic [2:0] in_action;
  logic [7:0] in_data;
  logic       in_bus;
  logic       out_vld;
  logic       advance;
  logic       step;

  // Pipeline moves when the result register is empty or being taken.
  assign advance   = !out_vld || res.ready;
  assign step      = in_vld && advance;
  assign cmd.ready = !in_vld || advance;
  assign cfg.ready = 1'b1;

  // Timing registers.
  owbm_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (cmd.ready) begin
      in_vld <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_action <= cmd.action;
      in_data   <= cmd.data;
      in_bus    <= cmd.bus_sample;
    end
  end

  // Sequencing state and step logic.
  owbm_engine #(
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .action     (in_action),
    .data       (in_data),
    .bus_sample (in_bus),
    .cfg        (cfg_regs),
    .res        (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= step_res;
    end
  end

  assign res.valid     = out_vld;
  assign res.drive_low = out_res.drive_low;
  assign res.busy_res  = out_res.busy_res;
  assign res.done_res  = out_res.done_res;
  assign res.presence  = out_res.presence;
  assign res.read_data = out_res.read_data;
  assign res.rejected  = out_res.rejected;

endmodule
